// File: sv/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

  // Framing bytes
  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] KIND_LOW    = 8'h01;
  localparam logic [7:0] KIND_LONG   = 8'h04;
  localparam logic [7:0] TRAILER     = 8'h0A;

  // Frame lengths in bytes, sync pair included
  localparam logic [4:0] SHORT_LEN = 5'd19;
  localparam logic [4:0] LONG_LEN  = 5'd23;

  // Byte positions with a fixed meaning
  localparam logic [4:0] POS_HUNT  = 5'd0;
  localparam logic [4:0] POS_SYNC2 = 5'd1;
  localparam logic [4:0] POS_SKIP  = 5'd2;
  localparam logic [4:0] POS_KIND  = 5'd3;
  localparam logic [4:0] POS_BODY  = 5'd4;

  // Positions 12..15 carry the payload word; they share these upper bits
  localparam logic [2:0] WORD_POS_HI = 3'b011;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned WORD_W = 32;

  typedef struct packed {
    logic              vld;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
  } sfd_res_t;

endpackage

// File: sv/sfd_parser.sv
`timescale 1ns / 1ps

module sfd_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_vld,
  input  logic [7:0]      byte_in,
  output sfd_pkg::sfd_res_t res
);
  import sfd_pkg::*;

  logic [4:0]        pos_r, pos_nxt;
  logic [4:0]        len_r, len_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [4:0]        pos_inc;

  assign pos_inc = pos_r + 5'd1;

  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    kind_nxt = kind_r;
    word_nxt = word_r;
    res.vld  = 1'b0;
    res.kind = kind_r;
    res.word = word_r;
    if (byte_vld) begin
      if (pos_r == POS_HUNT) begin
        if (byte_in == SYNC_FIRST) pos_nxt = POS_SYNC2;
      end else if (pos_r == POS_SYNC2) begin
        if (byte_in == SYNC_SECOND) pos_nxt = POS_SKIP;
        else if (byte_in == SYNC_FIRST) pos_nxt = POS_SYNC2;
        else pos_nxt = POS_HUNT;
      end else if (pos_r == POS_SKIP) begin
        pos_nxt = POS_KIND;
      end else if (pos_r == POS_KIND) begin
        if (byte_in >= KIND_LOW && byte_in < KIND_LONG) begin
          len_nxt  = SHORT_LEN;
          kind_nxt = byte_in[KIND_W-1:0];
          pos_nxt  = POS_BODY;
        end else if (byte_in == KIND_LONG) begin
          len_nxt  = LONG_LEN;
          kind_nxt = byte_in[KIND_W-1:0];
          pos_nxt  = POS_BODY;
        end else begin
          pos_nxt = POS_HUNT;
          len_nxt = '0;
        end
      end else if (len_r == '0 || pos_r >= len_r) begin
        // state that stepping never reaches: resync
        pos_nxt = POS_HUNT;
        len_nxt = '0;
      end else begin
        if (pos_r[4:2] == WORD_POS_HI) begin
          case (pos_r[1:0])
            2'd0:    word_nxt[7:0]   = byte_in;
            2'd1:    word_nxt[15:8]  = byte_in;
            2'd2:    word_nxt[23:16] = byte_in;
            default: word_nxt[31:24] = byte_in;
          endcase
        end
        if (pos_inc == len_r) begin
          pos_nxt = POS_HUNT;
          len_nxt = '0;
          res.vld = (byte_in == TRAILER);
        end else begin
          pos_nxt = pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HUNT;
      len_r  <= '0;
      kind_r <= '0;
      word_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      kind_r <= kind_nxt;
      word_r <= word_nxt;
    end
  end

endmodule

// File: sv/sfd_obuf.sv
`timescale 1ns / 1ps

module sfd_obuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfd_pkg::sfd_res_t             push,
  output logic                          rdy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sfd_pkg::KIND_W-1:0]    out_frame_kind,
  output logic [sfd_pkg::WORD_W-1:0]    out_payload_word
);
  import sfd_pkg::*;

  logic              out_vld_r, out_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt, skid_kind_r, skid_kind_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt, skid_word_r, skid_word_nxt;
  logic              pop;

  assign pop = out_vld_r && !out_stall;
  assign rdy = !skid_vld_r;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_kind_nxt  = out_kind_r;
    out_word_nxt  = out_word_r;
    skid_vld_nxt  = skid_vld_r;
    skid_kind_nxt = skid_kind_r;
    skid_word_nxt = skid_word_r;
    if (skid_vld_r) begin
      // upstream is held off while the skid is full
      if (pop) begin
        out_kind_nxt = skid_kind_r;
        out_word_nxt = skid_word_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push.vld) begin
      if (!out_vld_r || pop) begin
        out_vld_nxt  = 1'b1;
        out_kind_nxt = push.kind;
        out_word_nxt = push.word;
      end else begin
        skid_vld_nxt  = 1'b1;
        skid_kind_nxt = push.kind;
        skid_word_nxt = push.word;
      end
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_kind_r  <= out_kind_nxt;
    out_word_r  <= out_word_nxt;
    skid_kind_r <= skid_kind_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_frame_kind   = out_kind_r;
  assign out_payload_word = out_word_r;

endmodule

// File: sv/sensor_frame_deframer.sv
`timescale 1ns / 1ps

// Byte-stream deframer for a sensor link. Bytes enter one request at a time on
// the in_ channel. The block hunts for the sync pair 0x55 0xAA (a repeated
// 0x55 keeps the hunt armed), skips one byte, then reads a type byte: 1..3
// opens a 19-byte frame, 4 a 23-byte frame, anything else drops back to
// hunting. When the final byte of a frame is 0x0A, one request appears on the
// out_ channel carrying the type and the little-endian word from frame bytes
// 12..15; a frame with any other final byte is dropped without notice. The
// block takes one byte per clock when the out_ side keeps up; the final byte
// is held in the input register until the parser consumes it, the parser
// result is registered into the output buffer, and out_valid rises once it
// sits in the output register. A two-entry output buffer lets input keep
// flowing while a result waits; in_stall rises only once both entries are full.

module sensor_frame_deframer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sfd_pkg::KIND_W-1:0] out_frame_kind,
  output logic [sfd_pkg::WORD_W-1:0] out_payload_word
);
  import sfd_pkg::*;

  // input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r, in_byte_nxt;
  logic       obuf_rdy;
  logic       consume;
  sfd_res_t   res;

  // the parser consumes the held byte whenever the output buffer has room
  assign consume  = in_vld_r && obuf_rdy;
  assign in_stall = in_vld_r && !obuf_rdy;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_byte_nxt = in_byte_r;
    if (!in_stall) begin
      in_vld_nxt  = in_valid;
      in_byte_nxt = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
    in_byte_r <= in_byte_nxt;
  end

  sfd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (consume),
    .byte_in  (in_byte_r),
    .res      (res)
  );

  sfd_obuf u_obuf (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (res),
    .rdy              (obuf_rdy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_kind   (out_frame_kind),
    .out_payload_word (out_payload_word)
  );

endmodule

// File: sv/sfd_checker.sv
`timescale 1ns / 1ps

module sfd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [7:0]                 in_byte,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [sfd_pkg::KIND_W-1:0] out_frame_kind,
  input logic [sfd_pkg::WORD_W-1:0] out_payload_word
);

  // nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // only legal frame types are reported
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_kind != 3'd0 && out_frame_kind <= 3'd4))
    else $error("result with bad frame type");

  // input backs up only behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // a stalled input request holds still
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_byte)))
    else $error("stalled input request changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_frame_kind)
                                  && $stable(out_payload_word)))
    else $error("stalled result changed");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_byte          (in_byte),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_frame_kind   (out_frame_kind),
  .out_payload_word (out_payload_word)
);
